/* hdl/cseg_pkg.sv */
// Shared constants for the circle / segment intersection core.
// No dependencies; used by cseg_mul and circle_segment_intersection_core.
package cseg_pkg;

  // Width of one partial-product operand in the split multiplier
  localparam int MUL_CHUNK = 32;

  // Register stages from multiplier operands to product
  localparam int MUL_LAT = 4;

endpackage

/* hdl/cseg_if.sv */
// Valid/ready channel interfaces for the intersection core: query and result beats.
// No dependencies.
interface cseg_query_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic        [COORD_WIDTH-2:0] circle_radius;

  modport source (
    output valid, start_x, start_y, end_x, end_y, center_x, center_y, circle_radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, center_x, center_y, circle_radius,
    output ready
  );
endinterface

interface cseg_result_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          exit_root;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (
    output valid, hit, exit_root, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, hit, exit_root, point_x, point_y,
    output ready
  );
endinterface

/* hdl/cseg_mul.sv */
// Pipelined signed multiplier built from MUL_CHUNK x MUL_CHUNK partial products.
// Depends on cseg_pkg. Registers operands, partial products, row sums and product in turn, advancing on en.
module cseg_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);

  localparam int CK = cseg_pkg::MUL_CHUNK;
  localparam int NA = (AW + CK - 1) / CK;
  localparam int NB = (BW + CK - 1) / CK;
  localparam int XA = NA * CK;
  localparam int XB = NB * CK;
  localparam int RW = XB + CK;
  localparam int SW = XA + XB;
  localparam int PW = AW + BW;

  logic [AW-1:0]     a_mag;
  logic [BW-1:0]     b_mag;
  logic [XA-1:0]     ma;
  logic [XB-1:0]     mb;
  logic              sg1, sg2, sg3;
  logic [2*CK-1:0]   pp [NA][NB];
  logic [RW-1:0]     row_next [NA];
  logic [RW-1:0]     row [NA];
  logic [SW-1:0]     sum;

  // operand magnitudes, sign handled separately
  assign a_mag = a[AW-1] ? (~a + AW'(1)) : a;
  assign b_mag = b[BW-1] ? (~b + BW'(1)) : b;

  // sum of each row of partial products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (CK * j));
      end
    end
  end

  // final sum of the rows
  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      sum = sum + (SW'(row[i]) << (CK * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma  <= XA'(a_mag);
      mb  <= XB'(b_mag);
      sg1 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= (2*CK)'(ma[CK*i +: CK]) * (2*CK)'(mb[CK*j +: CK]);
        end
      end
      sg2 <= sg1;
      row <= row_next;
      sg3 <= sg2;
      p   <= PW'(sg3 ? (~sum + SW'(1)) : sum);
    end
  end

endmodule

/* hdl/circle_segment_intersection_core.sv */
// Circle / line-segment intersection: one query beat in, one result beat out.
// Depends on cseg_pkg, cseg_if (cseg_query_if, cseg_result_if) and cseg_mul.
//
// Fully pipelined: a new query is taken every cycle unless the output stalls.
// Its main parts are the bit-per-stage integer square root of the
// discriminant (2*COORD_WIDTH stages), the bit-per-stage round-to-nearest
// divider for the point offset (COORD_WIDTH+1 stages) and three rounds of
// split multipliers.
// The whole pipeline holds while a finished result waits on the output.
// Arithmetic is exact: the nearer root is tried first, then the farther one;
// with no hit all result fields other than hit read zero.
module circle_segment_intersection_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  cseg_query_if.sink     query,
  cseg_result_if.source  result
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;          // differences
  localparam int AW   = 2 * W + 2;      // a = d.d
  localparam int HW   = 2 * W + 3;      // h, c
  localparam int PW1  = 2 * DW;
  localparam int SW2  = 2 * HW;
  localparam int XW   = 4 * W;          // radicand
  localparam int QW   = 2 * W;          // square root
  localparam int NW   = 2 * W + 4;      // root numerators
  localparam int PW3  = DW + AW + 1;
  localparam int NUMW = 3 * W + 4;
  localparam int QDW  = W + 1;          // offset quotient
  localparam int ML   = cseg_pkg::MUL_LAT;

  // stage numbers (registers after the accepting edge)
  localparam int K_AHC  = 1 + ML + 1;
  localparam int K_DISC = K_AHC + ML + 1;
  localparam int K_SQ   = K_DISC + QW;
  localparam int K_N12  = K_SQ + 1;
  localparam int K_N    = K_SQ + 2;
  localparam int K_PR   = K_N + ML;
  localparam int K_DD   = K_PR + 1;
  localparam int K_Q    = K_DD + QDW;
  localparam int LAT    = K_Q + 1;

  logic           en;
  logic [LAT-1:0] vld;

  // pipeline advance: holds only while the output beat is stalled
  assign en          = ~vld[LAT-1] | result.ready;
  assign query.ready = en & ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], query.valid};
    end
  end

  // stage 1: differences
  logic [W-1:0]  sx1, sy1;
  logic [DW-1:0] dx1, dy1, px1, py1, r1;
  logic [W-1:0]  i_sx, i_sy, i_ex, i_ey, i_cx, i_cy;

  assign i_sx = query.start_x;
  assign i_sy = query.start_y;
  assign i_ex = query.end_x;
  assign i_ey = query.end_y;
  assign i_cx = query.center_x;
  assign i_cy = query.center_y;

  always_ff @(posedge clk) begin
    if (en) begin
      sx1 <= i_sx;
      sy1 <= i_sy;
      dx1 <= {i_ex[W-1], i_ex} - {i_sx[W-1], i_sx};
      dy1 <= {i_ey[W-1], i_ey} - {i_sy[W-1], i_sy};
      px1 <= {i_sx[W-1], i_sx} - {i_cx[W-1], i_cx};
      py1 <= {i_sy[W-1], i_sy} - {i_cy[W-1], i_cy};
      r1  <= {2'b00, query.circle_radius};
    end
  end

  // first products
  logic [PW1-1:0] m_dxdx, m_dydy, m_dxpx, m_dypy, m_pxpx, m_pypy, m_rr;

  cseg_mul #(.AW(DW), .BW(DW)) u_dxdx (.clk, .en, .a(dx1), .b(dx1), .p(m_dxdx));
  cseg_mul #(.AW(DW), .BW(DW)) u_dydy (.clk, .en, .a(dy1), .b(dy1), .p(m_dydy));
  cseg_mul #(.AW(DW), .BW(DW)) u_dxpx (.clk, .en, .a(dx1), .b(px1), .p(m_dxpx));
  cseg_mul #(.AW(DW), .BW(DW)) u_dypy (.clk, .en, .a(dy1), .b(py1), .p(m_dypy));
  cseg_mul #(.AW(DW), .BW(DW)) u_pxpx (.clk, .en, .a(px1), .b(px1), .p(m_pxpx));
  cseg_mul #(.AW(DW), .BW(DW)) u_pypy (.clk, .en, .a(py1), .b(py1), .p(m_pypy));
  cseg_mul #(.AW(DW), .BW(DW)) u_rr   (.clk, .en, .a(r1),  .b(r1),  .p(m_rr));

  // quadratic coefficients
  logic [AW-1:0] a_c;
  logic [HW-1:0] h_c, c_c;

  always_ff @(posedge clk) begin
    if (en) begin
      a_c <= AW'(m_dxdx) + AW'(m_dydy);
      h_c <= {m_dxpx[PW1-1], m_dxpx} + {m_dypy[PW1-1], m_dypy};
      c_c <= {m_pxpx[PW1-1], m_pxpx} + {m_pypy[PW1-1], m_pypy} - {m_rr[PW1-1], m_rr};
    end
  end

  // delay lines for a and h
  logic [AW-1:0] a_dl [K_PR-K_AHC];
  logic [HW-1:0] h_dl [K_SQ-K_AHC];

  always_ff @(posedge clk) begin
    if (en) begin
      a_dl[0] <= a_c;
      for (int i = 1; i < K_PR - K_AHC; i++) a_dl[i] <= a_dl[i-1];
      h_dl[0] <= h_c;
      for (int i = 1; i < K_SQ - K_AHC; i++) h_dl[i] <= h_dl[i-1];
    end
  end

  // discriminant products
  logic [SW2-1:0] m_hh, m_ac;

  cseg_mul #(.AW(HW), .BW(HW)) u_hh (.clk, .en, .a(h_c), .b(h_c), .p(m_hh));
  cseg_mul #(.AW(HW), .BW(HW)) u_ac (.clk, .en, .a({1'b0, a_c}), .b(c_c), .p(m_ac));

  logic [SW2-1:0] disc;
  logic [AW-1:0]  a_at_disc;

  assign disc      = m_hh - m_ac;
  assign a_at_disc = a_dl[K_DISC-K_AHC-2];

  // square root: one result bit per stage
  logic [XW-1:0] sq_x [QW];
  logic [XW-1:0] sq_r [QW+1];
  logic          miss_dl [K_N12-K_DISC+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]    <= disc[SW2-1] ? '0 : disc[XW-1:0];
      sq_r[0]    <= '0;
      miss_dl[0] <= disc[SW2-1] | (a_at_disc == '0);
      for (int i = 1; i < K_N12 - K_DISC + 1; i++) miss_dl[i] <= miss_dl[i-1];
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_sqrt
    localparam logic [XW-1:0] BITV = XW'(1) << (2 * (QW - j));
    logic [XW-1:0] trial;
    logic          take;

    assign trial = sq_r[j-1] + BITV;
    assign take  = sq_x[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[j] <= take ? ((sq_r[j-1] >> 1) + BITV) : (sq_r[j-1] >> 1);
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sq_x[j] <= take ? (sq_x[j-1] - trial) : sq_x[j-1];
        end
      end
    end
  end

  // root numerators
  logic [NW-1:0] n1, n2, h_ext, q_ext;
  logic [HW-1:0] h_at_sq;

  assign h_at_sq = h_dl[K_SQ-K_AHC-1];
  assign h_ext   = {{(NW-HW){h_at_sq[HW-1]}}, h_at_sq};
  assign q_ext   = NW'(sq_r[QW][QW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= (~h_ext + NW'(1)) - q_ext;
      n2 <= (~h_ext + NW'(1)) + q_ext;
    end
  end

  // root selection against [0,1]
  logic [NW-1:0] a_ext;
  logic          u1, u2;
  logic [AW-1:0] n_sel;
  logic          hit_n, which_n;

  assign a_ext = NW'(a_dl[K_N12-K_AHC-1]);
  assign u1    = ~n1[NW-1] && (n1 <= a_ext);
  assign u2    = ~n2[NW-1] && (n2 <= a_ext);

  always_ff @(posedge clk) begin
    if (en) begin
      hit_n   <= ~miss_dl[K_N12-K_DISC] & (u1 | u2);
      which_n <= ~u1;
      n_sel   <= u1 ? n1[AW-1:0] : n2[AW-1:0];
    end
  end

  // delay lines for start point, direction and flags
  logic [W-1:0]  sx_dl [K_Q-1];
  logic [W-1:0]  sy_dl [K_Q-1];
  logic [DW-1:0] dx_dl [K_N-1];
  logic [DW-1:0] dy_dl [K_N-1];
  logic          hit_dl [K_Q-K_N];
  logic          which_dl [K_Q-K_N];

  always_ff @(posedge clk) begin
    if (en) begin
      sx_dl[0] <= sx1;
      sy_dl[0] <= sy1;
      for (int i = 1; i < K_Q - 1; i++) begin
        sx_dl[i] <= sx_dl[i-1];
        sy_dl[i] <= sy_dl[i-1];
      end
      dx_dl[0] <= dx1;
      dy_dl[0] <= dy1;
      for (int i = 1; i < K_N - 1; i++) begin
        dx_dl[i] <= dx_dl[i-1];
        dy_dl[i] <= dy_dl[i-1];
      end
      hit_dl[0]   <= hit_n;
      which_dl[0] <= which_n;
      for (int i = 1; i < K_Q - K_N; i++) begin
        hit_dl[i]   <= hit_dl[i-1];
        which_dl[i] <= which_dl[i-1];
      end
    end
  end

  // offset products d * n
  logic [PW3-1:0] m_xn, m_yn;

  cseg_mul #(.AW(DW), .BW(AW+1)) u_xn (
    .clk, .en, .a(dx_dl[K_N-2]), .b({1'b0, n_sel}), .p(m_xn)
  );
  cseg_mul #(.AW(DW), .BW(AW+1)) u_yn (
    .clk, .en, .a(dy_dl[K_N-2]), .b({1'b0, n_sel}), .p(m_yn)
  );

  // dividend 2|d*n| + a, divisor 2a
  logic [PW3-1:0] mag_x, mag_y;
  logic [AW-1:0]  a_at_pr;

  assign mag_x   = m_xn[PW3-1] ? (~m_xn + PW3'(1)) : m_xn;
  assign mag_y   = m_yn[PW3-1] ? (~m_yn + PW3'(1)) : m_yn;
  assign a_at_pr = a_dl[K_PR-K_AHC-1];

  logic [NUMW-1:0] dv_rx [QDW];
  logic [NUMW-1:0] dv_ry [QDW];
  logic [AW:0]     dv_den [QDW];
  logic [QDW-1:0]  dq_x [QDW+1];
  logic [QDW-1:0]  dq_y [QDW+1];
  logic            neg_x_dl [QDW+1];
  logic            neg_y_dl [QDW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rx[0]    <= NUMW'({mag_x, 1'b0}) + NUMW'(a_at_pr);
      dv_ry[0]    <= NUMW'({mag_y, 1'b0}) + NUMW'(a_at_pr);
      dv_den[0]   <= {a_at_pr, 1'b0};
      dq_x[0]     <= '0;
      dq_y[0]     <= '0;
      neg_x_dl[0] <= m_xn[PW3-1];
      neg_y_dl[0] <= m_yn[PW3-1];
      for (int i = 1; i < QDW + 1; i++) begin
        neg_x_dl[i] <= neg_x_dl[i-1];
        neg_y_dl[i] <= neg_y_dl[i-1];
      end
    end
  end

  // restoring division: one quotient bit per stage, both axes share the divisor
  for (genvar i = 1; i <= QDW; i++) begin : g_div
    localparam int BIT = QDW - i;
    logic [NUMW-1:0] dsh;
    logic            tx, ty;

    assign dsh = NUMW'(dv_den[i-1]) << BIT;
    assign tx  = dv_rx[i-1] >= dsh;
    assign ty  = dv_ry[i-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        dq_x[i] <= dq_x[i-1] | (QDW'(tx) << BIT);
        dq_y[i] <= dq_y[i-1] | (QDW'(ty) << BIT);
      end
    end

    if (i < QDW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rx[i]  <= tx ? (dv_rx[i-1] - dsh) : dv_rx[i-1];
          dv_ry[i]  <= ty ? (dv_ry[i-1] - dsh) : dv_ry[i-1];
          dv_den[i] <= dv_den[i-1];
        end
      end
    end
  end

  // output register: point = start + signed offset
  logic [W-1:0] off_x, off_y;
  logic         hit_q;
  logic         hit_o, exit_o;
  logic [W-1:0] pt_x, pt_y;

  assign off_x = neg_x_dl[QDW] ? (~W'(dq_x[QDW]) + W'(1)) : W'(dq_x[QDW]);
  assign off_y = neg_y_dl[QDW] ? (~W'(dq_y[QDW]) + W'(1)) : W'(dq_y[QDW]);
  assign hit_q = hit_dl[K_Q-K_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_o  <= hit_q;
      exit_o <= hit_q & which_dl[K_Q-K_N-1];
      pt_x   <= hit_q ? (sx_dl[K_Q-2] + off_x) : '0;
      pt_y   <= hit_q ? (sy_dl[K_Q-2] + off_y) : '0;
    end
  end

  assign result.valid     = vld[LAT-1];
  assign result.hit       = hit_o;
  assign result.exit_root = exit_o;
  assign result.point_x   = pt_x;
  assign result.point_y   = pt_y;

endmodule

/* tb/tb_circle_segment_intersection_core.sv */
// Self-checking bench for circle_segment_intersection_core: random and directed queries.
// Depends on cseg_pkg, cseg_if and the core; predicts each result with exact wide arithmetic.
module tb_circle_segment_intersection_core;

  localparam int CW = 32;
  localparam int LAT = 3 * CW + 20;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic          hit;
    logic          exit_root;
    logic [CW-1:0] point_x;
    logic [CW-1:0] point_y;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cseg_query_if  #(.COORD_WIDTH(CW)) query ();
  cseg_result_if #(.COORD_WIDTH(CW)) result ();

  circle_segment_intersection_core #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst), .query(query), .result(result)
  );

  isect_t pending_isect[$];
  int     n_fail = 0;
  int     n_sent = 0;
  int     n_hits = 0;
  int     n_exit = 0;
  int     n_rcvd = 0;
  int     burst_left = 0;
  int     stall_mode = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Floor square root, bit by bit
  function automatic wide_t isqrt_wide(input wide_t x);
    wide_t res, t;
    res = 0;
    for (int k = 127; k >= 0; k--) begin
      t = res + (wide_t'(1) << (2 * k));
      if (x >= t) begin
        x = x - t;
        res = (res >>> 1) + (wide_t'(1) << (2 * k));
      end else begin
        res = res >>> 1;
      end
    end
    return res;
  endfunction

  // start + d*n/a, rounded to nearest with ties away from zero
  function automatic logic [CW-1:0] offset_point(input wide_t st, input wide_t d,
                                                 input wide_t n, input wide_t a);
    wide_t prod, mag, q;
    prod = d * n;
    mag = (prod < 0) ? -prod : prod;
    q = (2 * mag + a) / (2 * a);
    if (prod < 0) q = -q;
    return CW'(st + q);
  endfunction

  function automatic isect_t predict_isect(input logic [CW-1:0] sx_i, sy_i, ex_i, ey_i,
                                           cx_i, cy_i, input logic [CW-2:0] r_i);
    wide_t sx, sy, dx, dy, px, py, a, h, c, disc, q, n1, n2, n;
    isect_t o;
    o = '0;
    sx = wide_t'($signed(sx_i));
    sy = wide_t'($signed(sy_i));
    dx = wide_t'($signed(ex_i)) - sx;
    dy = wide_t'($signed(ey_i)) - sy;
    px = sx - wide_t'($signed(cx_i));
    py = sy - wide_t'($signed(cy_i));
    a = dx * dx + dy * dy;
    h = dx * px + dy * py;
    c = px * px + py * py - wide_t'(r_i) * wide_t'(r_i);
    if (a == 0) return o;
    disc = h * h - a * c;
    if (disc < 0) return o;
    q = isqrt_wide(disc);
    n1 = -h - q;
    n2 = -h + q;
    if (n1 >= 0 && n1 <= a) begin
      n = n1;
    end else if (n2 >= 0 && n2 <= a) begin
      n = n2;
      o.exit_root = 1'b1;
    end else begin
      return o;
    end
    o.hit = 1'b1;
    o.point_x = offset_point(sx, dx, n, a);
    o.point_y = offset_point(sy, dy, n, a);
    return o;
  endfunction

  // Drive one query beat with bursty gaps, wait for acceptance
  task automatic send_query(input logic [CW-1:0] sx, sy, ex, ey, cx, cy,
                            input logic [CW-2:0] r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    if (gap > 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query.valid <= 1'b1;
    query.start_x <= sx;
    query.start_y <= sy;
    query.end_x <= ex;
    query.end_y <= ey;
    query.center_x <= cx;
    query.center_y <= cy;
    query.circle_radius <= r;
    do @(posedge clk); while (!query.ready);
    pending_isect.push_back(predict_isect(sx, sy, ex, ey, cx, cy, r));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    query.valid <= 1'b0;
    do @(negedge clk); while (pending_isect.size() != 0);
  endtask

  // Random coordinate: sometimes full range, mostly near a scale
  function automatic logic [CW-1:0] rand_coord(input int span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return CW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic test_directed();
    logic [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    // zero-length segment
    send_query(0, 0, 0, 0, 0, 0, 31'h10000);
    // entry hit from outside
    send_query(-32'sh30000, 0, 32'sh30000, 0, 0, 0, 31'h10000);
    // start inside: exit root
    send_query(0, 0, 32'sh30000, 0, 0, 0, 31'h10000);
    // miss: negative discriminant
    send_query(-32'sh30000, 32'sh50000, 32'sh30000, 32'sh50000, 0, 0, 31'h10000);
    // tangent
    send_query(-32'sh30000, 32'sh10000, 32'sh30000, 32'sh10000, 0, 0, 31'h10000);
    // roots beyond the segment
    send_query(32'sh20000, 0, 32'sh30000, 0, 0, 0, 31'h10000);
    // whole segment inside: neither root in range
    send_query(0, 0, 32'h100, 0, 0, 0, 31'h100000);
    // zero radius with point on segment
    send_query(-32'sh10000, 0, 32'sh10000, 0, 0, 0, 0);
    // extremes of every field
    send_query(mn, mn, mx, mx, 0, 0, {(CW-1){1'b1}});
    send_query(mx, mn, mn, mx, mx, mx, {(CW-1){1'b1}});
    send_query(mx, mx, mn, mn, mn, mn, 0);
    send_query('1, '1, '1, 0, '1, 0, 1);
    send_query(mn, 0, mx, 0, 0, mn, {(CW-1){1'b1}});
    send_query(0, mx, 0, mn, mx, 0, 31'h7fff0000);
  endtask

  task automatic test_random(input int count);
    logic [CW-1:0] cx, cy;
    int span;
    for (int i = 0; i < count; i++) begin
      span = $urandom_range(0, 3) == 0 ? 32'h7fffffff : (1 << $urandom_range(4, 28));
      cx = rand_coord(span);
      cy = rand_coord(span);
      if (i == count / 2) drain_results();
      send_query(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                 cx, cy,
                 (CW-1)'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, span)));
    end
  endtask

  // Receiver stall pattern: phases of none, light and heavy back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: result.ready <= 1'b1;
      1: result.ready <= ($urandom_range(0, 3) != 0);
      default: result.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    isect_t want;
    if (!rst && result.valid && result.ready) begin
      n_rcvd++;
      if (pending_isect.size() == 0) begin
        $display("%0t: unexpected result beat hit=%b", $time, result.hit);
        n_fail++;
      end else begin
        want = pending_isect.pop_front();
        if (want.hit) n_hits++;
        if (want.exit_root) n_exit++;
        if (result.hit !== want.hit) begin
          $display("%0t: hit exp %b got %b", $time, want.hit, result.hit);
          n_fail++;
        end
        if (result.exit_root !== want.exit_root) begin
          $display("%0t: exit_root exp %b got %b", $time, want.exit_root, result.exit_root);
          n_fail++;
        end
        if (result.point_x !== want.point_x) begin
          $display("%0t: point_x exp %h got %h", $time, want.point_x, result.point_x);
          n_fail++;
        end
        if (result.point_y !== want.point_y) begin
          $display("%0t: point_y exp %h got %h", $time, want.point_y, result.point_y);
          n_fail++;
        end
      end
    end
  end

  initial begin
    query.valid = 1'b0;
    query.start_x = '0;
    query.start_y = '0;
    query.end_x = '0;
    query.end_y = '0;
    query.center_x = '0;
    query.center_y = '0;
    query.circle_radius = '0;
    result.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(1200);
    drain_results();
    repeat (LAT + 10) @(negedge clk);
    $display("Sent %0d queries, checked %0d results (%0d hits, %0d on the exit root).",
             n_sent, n_rcvd, n_hits, n_exit);
    if (n_fail == 0 && pending_isect.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
